// ===== sv/plex_pkg.sv =====
// Shared types, character codes and helpers for the propositional logic lexer.
// Used by plex_front, plex_queue, plex_back and propositional_logic_lexer.
`timescale 1ns / 1ps
`default_nettype none

package plex_pkg;

  // Width of the internal character position counters.
  localparam int unsigned POS_BITS = 16;
  // Width of position and length fields on the result stream.
  localparam int unsigned OUT_POS_W = 16;
  // Bundles held between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  // Most tokens one character can cause.
  localparam int unsigned MAX_TOK = 3;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;  // !
  localparam logic [7:0] CH_AMP   = 8'h26;  // &
  localparam logic [7:0] CH_LPAR  = 8'h28;  // (
  localparam logic [7:0] CH_RPAR  = 8'h29;  // )
  localparam logic [7:0] CH_MINUS = 8'h2D;  // -
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;  // _
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7A;
  localparam logic [7:0] CH_PIPE  = 8'h7C;  // |

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NAME,
    MODE_MINUS,
    MODE_LT,
    MODE_LTMINUS,
    MODE_DROP
  } lex_mode_e;

  typedef enum logic [3:0] {
    TOK_VAR     = 4'd0,
    TOK_AND     = 4'd1,
    TOK_OR      = 4'd2,
    TOK_NOT     = 4'd3,
    TOK_IMPLIES = 4'd4,
    TOK_IFF     = 4'd5,
    TOK_LPAREN  = 4'd6,
    TOK_RPAREN  = 4'd7,
    TOK_END     = 4'd8,
    TOK_ERROR   = 4'd9
  } token_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_ARROW    = 3'd1,
    ERR_DIGIT_FIRST  = 3'd2,
    ERR_INVALID_CHAR = 3'd3,
    ERR_TOO_LONG     = 3'd4
  } error_kind_e;

  typedef struct packed {
    token_kind_e           kind;
    error_kind_e           err;
    logic [OUT_POS_W-1:0]  pos;
    logic [OUT_POS_W-1:0]  len;
  } token_t;

  // All tokens caused by one character; cnt is 1..MAX_TOK.
  typedef struct packed {
    logic [1:0]              cnt;
    token_t [MAX_TOK-1:0]    tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Position to output width: truncate or zero-extend.
  function automatic logic [OUT_POS_W-1:0] to_out(input logic [POS_BITS-1:0] p);
    logic [POS_BITS+OUT_POS_W-1:0] ext;
    ext = {{OUT_POS_W{1'b0}}, p};
    return ext[OUT_POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/plex_front.sv =====
// Front end of the lexer: per-character mode machine and token bundle builder.
// Depends on plex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plex_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              last_char_i,
  output logic                   push_o,
  output plex_pkg::bundle_t      bundle_o
);

  localparam int unsigned PB = plex_pkg::POS_BITS;

  plex_pkg::lex_mode_e mode_q, mode_d, mode_mid;
  logic [PB-1:0] pos_q, pos_d;
  logic [PB-1:0] ident_start_q, ident_start_d, ident_start_mid;
  logic [PB-1:0] ident_len_q, ident_len_d, ident_len_mid;
  logic [PB-1:0] op_start_q, op_start_d, op_start_mid;
  logic          err_hit;

  logic c_ws, c_op1, c_arrow, c_digit, c_name, at_limit;
  plex_pkg::token_kind_e op1_kind;

  assign c_ws     = (char_code_i == plex_pkg::CH_SPACE) || (char_code_i == plex_pkg::CH_TAB)
                 || (char_code_i == plex_pkg::CH_NL);
  assign c_arrow  = (char_code_i == plex_pkg::CH_MINUS) || (char_code_i == plex_pkg::CH_LT);
  assign c_digit  = (char_code_i >= plex_pkg::CH_DIG0) && (char_code_i <= plex_pkg::CH_DIG9);
  assign c_name   = c_digit || (char_code_i == plex_pkg::CH_UNDER)
                 || ((char_code_i >= plex_pkg::CH_UPA) && (char_code_i <= plex_pkg::CH_UPZ))
                 || ((char_code_i >= plex_pkg::CH_LOA) && (char_code_i <= plex_pkg::CH_LOZ));
  assign at_limit = (pos_q == {PB{1'b1}});

  always_comb begin
    c_op1    = 1'b1;
    op1_kind = plex_pkg::TOK_RPAREN;
    unique case (char_code_i)
      plex_pkg::CH_AMP:  op1_kind = plex_pkg::TOK_AND;
      plex_pkg::CH_PIPE: op1_kind = plex_pkg::TOK_OR;
      plex_pkg::CH_BANG: op1_kind = plex_pkg::TOK_NOT;
      plex_pkg::CH_LPAR: op1_kind = plex_pkg::TOK_LPAREN;
      plex_pkg::CH_RPAR: op1_kind = plex_pkg::TOK_RPAREN;
      default:           c_op1 = 1'b0;
    endcase
  end

  // Mode and lexer state after this character, before end-of-text handling.
  always_comb begin
    mode_mid        = mode_q;
    err_hit         = 1'b0;
    ident_start_mid = ident_start_q;
    ident_len_mid   = ident_len_q;
    op_start_mid    = op_start_q;
    if (at_limit) begin
      err_hit = 1'b1;
    end else begin
      unique case (mode_q)
        plex_pkg::MODE_MINUS, plex_pkg::MODE_LTMINUS: begin
          if (char_code_i == plex_pkg::CH_GT) mode_mid = plex_pkg::MODE_IDLE;
          else err_hit = 1'b1;
        end
        plex_pkg::MODE_LT: begin
          if (char_code_i == plex_pkg::CH_MINUS) mode_mid = plex_pkg::MODE_LTMINUS;
          else err_hit = 1'b1;
        end
        plex_pkg::MODE_IDLE, plex_pkg::MODE_NAME: begin
          if (c_ws || c_op1) begin
            mode_mid = plex_pkg::MODE_IDLE;
          end else if (c_arrow) begin
            op_start_mid = pos_q;
            mode_mid = (char_code_i == plex_pkg::CH_MINUS) ? plex_pkg::MODE_MINUS
                                                          : plex_pkg::MODE_LT;
          end else if ((mode_q == plex_pkg::MODE_IDLE) && c_digit) begin
            err_hit = 1'b1;
          end else if (!c_name) begin
            err_hit = 1'b1;
          end else if (mode_q == plex_pkg::MODE_IDLE) begin
            ident_start_mid = pos_q;
            ident_len_mid   = PB'(1);
            mode_mid        = plex_pkg::MODE_NAME;
          end else begin
            ident_len_mid = ident_len_q + PB'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    mode_d        = mode_q;
    pos_d         = pos_q;
    ident_start_d = ident_start_q;
    ident_len_d   = ident_len_q;
    op_start_d    = op_start_q;
    if (accept_i) begin
      if (mode_q == plex_pkg::MODE_DROP) begin
        if (last_char_i) begin
          mode_d = plex_pkg::MODE_IDLE;
          pos_d  = '0;
        end
      end else begin
        ident_start_d = ident_start_mid;
        ident_len_d   = ident_len_mid;
        op_start_d    = op_start_mid;
        if (last_char_i) begin
          mode_d = plex_pkg::MODE_IDLE;
          pos_d  = '0;
        end else if (err_hit) begin
          mode_d = plex_pkg::MODE_DROP;
        end else begin
          mode_d = mode_mid;
          pos_d  = pos_q + PB'(1);
        end
      end
    end
  end

  // Token bundle for this character.
  always_comb begin
    plex_pkg::token_t [plex_pkg::MAX_TOK-1:0] tok;
    logic [1:0] n;
    logic       arrow_pending;
    tok = '0;
    n   = 2'd0;
    arrow_pending = (mode_mid == plex_pkg::MODE_MINUS) || (mode_mid == plex_pkg::MODE_LT)
                 || (mode_mid == plex_pkg::MODE_LTMINUS);
    if (at_limit) begin
      tok[n] = '{plex_pkg::TOK_ERROR, plex_pkg::ERR_TOO_LONG, plex_pkg::to_out(pos_q), '0};
      n = n + 2'd1;
    end else begin
      unique case (mode_q)
        plex_pkg::MODE_MINUS: begin
          if (char_code_i == plex_pkg::CH_GT) begin
            tok[n] = '{plex_pkg::TOK_IMPLIES, plex_pkg::ERR_NONE,
                       plex_pkg::to_out(op_start_q), '0};
          end else begin
            tok[n] = '{plex_pkg::TOK_ERROR, plex_pkg::ERR_BAD_ARROW,
                       plex_pkg::to_out(op_start_q), '0};
          end
          n = n + 2'd1;
        end
        plex_pkg::MODE_LTMINUS: begin
          if (char_code_i == plex_pkg::CH_GT) begin
            tok[n] = '{plex_pkg::TOK_IFF, plex_pkg::ERR_NONE,
                       plex_pkg::to_out(op_start_q), '0};
          end else begin
            tok[n] = '{plex_pkg::TOK_ERROR, plex_pkg::ERR_BAD_ARROW,
                       plex_pkg::to_out(op_start_q), '0};
          end
          n = n + 2'd1;
        end
        plex_pkg::MODE_LT: begin
          if (char_code_i != plex_pkg::CH_MINUS) begin
            tok[n] = '{plex_pkg::TOK_ERROR, plex_pkg::ERR_BAD_ARROW,
                       plex_pkg::to_out(op_start_q), '0};
            n = n + 2'd1;
          end
        end
        plex_pkg::MODE_IDLE, plex_pkg::MODE_NAME: begin
          if (c_ws || c_op1 || c_arrow) begin
            if (mode_q == plex_pkg::MODE_NAME) begin
              tok[n] = '{plex_pkg::TOK_VAR, plex_pkg::ERR_NONE,
                         plex_pkg::to_out(ident_start_q), plex_pkg::to_out(ident_len_q)};
              n = n + 2'd1;
            end
            if (c_op1) begin
              tok[n] = '{op1_kind, plex_pkg::ERR_NONE, plex_pkg::to_out(pos_q), '0};
              n = n + 2'd1;
            end
          end else if ((mode_q == plex_pkg::MODE_IDLE) && c_digit) begin
            tok[n] = '{plex_pkg::TOK_ERROR, plex_pkg::ERR_DIGIT_FIRST,
                       plex_pkg::to_out(pos_q), '0};
            n = n + 2'd1;
          end else if (!c_name) begin
            tok[n] = '{plex_pkg::TOK_ERROR, plex_pkg::ERR_INVALID_CHAR,
                       plex_pkg::to_out(pos_q), '0};
            n = n + 2'd1;
          end
        end
        default: ;
      endcase
    end
    // End of text: report a pending arrow as an error, or close a pending name and add the end token.
    if (last_char_i && !err_hit) begin
      if (arrow_pending) begin
        tok[n] = '{plex_pkg::TOK_ERROR, plex_pkg::ERR_BAD_ARROW,
                   plex_pkg::to_out(op_start_mid), '0};
        n = n + 2'd1;
      end else begin
        if (mode_mid == plex_pkg::MODE_NAME) begin
          tok[n] = '{plex_pkg::TOK_VAR, plex_pkg::ERR_NONE,
                     plex_pkg::to_out(ident_start_mid), plex_pkg::to_out(ident_len_mid)};
          n = n + 2'd1;
        end
        tok[n] = '{plex_pkg::TOK_END, plex_pkg::ERR_NONE,
                   plex_pkg::to_out(pos_q + PB'(1)), '0};
        n = n + 2'd1;
      end
    end
    bundle_o.tok = tok;
    bundle_o.cnt = n;
    push_o = accept_i && (mode_q != plex_pkg::MODE_DROP) && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= plex_pkg::MODE_IDLE;
      pos_q         <= '0;
      ident_start_q <= '0;
      ident_len_q   <= '0;
      op_start_q    <= '0;
    end else begin
      mode_q        <= mode_d;
      pos_q         <= pos_d;
      ident_start_q <= ident_start_d;
      ident_len_q   <= ident_len_d;
      op_start_q    <= op_start_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/plex_queue.sv =====
// Small register queue of token bundles between lexer front and back.
// Depends on plex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plex_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  plex_pkg::bundle_t       push_data_i,
  input  wire logic               pop_i,
  output plex_pkg::bundle_t       head_o,
  output plex_pkg::q_status_t     status_o
);

  localparam int unsigned PW = plex_pkg::QPTR_W;

  plex_pkg::bundle_t   entries_q [plex_pkg::QDEPTH];
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]         count_q, count_d;

  assign head_o         = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == (PW+1)'(plex_pkg::QDEPTH));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/plex_back.sv =====
// Back end of the lexer: serializes token bundles into the output register.
// Depends on plex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plex_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  plex_pkg::bundle_t       head_i,
  input  plex_pkg::q_status_t     status_i,
  output logic                    pop_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output plex_pkg::token_t        out_tok_o,
  output logic                    out_last_o
);

  logic             valid_q, valid_d;
  plex_pkg::token_t tok_q, tok_d;
  logic             last_q, last_d;
  logic [1:0]       idx_q, idx_d;
  logic             load, at_end;

  assign load   = !valid_q || out_ready_i;
  assign at_end = (idx_q == (head_i.cnt - 2'd1));

  always_comb begin
    valid_d = valid_q;
    tok_d   = tok_q;
    last_d  = last_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !status_i.empty;
      if (!status_i.empty) begin
        tok_d  = head_i.tok[idx_q];
        last_d = at_end;
        pop_o  = at_end;
        idx_d  = at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== sv/propositional_logic_lexer.sv =====
// Top level of the propositional logic lexer: front, bundle queue and back.
// Depends on plex_pkg, plex_front, plex_queue and plex_back.
// A token passes through the bundle queue and the back end's output register before it is valid.
// Throughput: one character per cycle while the queue has a free slot; a character causing k tokens
// sends them out one at a time through the single output register in the back end.
// A four-bundle queue lets the front keep taking characters meanwhile.
// Reset (rst_ni low, asynchronous) returns the lexer to idle at position zero
// and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module propositional_logic_lexer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Character stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  wire logic        s_axis_tlast_i,   // last_char
  // Token stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [2:0] error_kind, [18:3] start_pos,
                                             // [34:19] span_len, [39:35] zero
  output logic [3:0]       m_axis_tuser_o,   // [3:0] token_kind
  output logic             m_axis_tlast_o    // last_of_run
);

  plex_pkg::bundle_t   bundle;
  plex_pkg::bundle_t   head;
  plex_pkg::q_status_t status;
  plex_pkg::token_t    out_tok;
  logic                push, pop, accept;

  // The front only waits when the queue has no free slot.
  assign s_axis_tready_o = !status.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  plex_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (s_axis_tdata_i),
    .last_char_i (s_axis_tlast_i),
    .push_o      (push),
    .bundle_o    (bundle)
  );

  plex_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (bundle),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (status)
  );

  plex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (status),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_tok_o   (out_tok),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pack the token fields onto the bus.
  assign m_axis_tuser_o = out_tok.kind;
  assign m_axis_tdata_o = {5'd0, out_tok.len, out_tok.pos, out_tok.err};

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for propositional_logic_lexer: a directed table, then
// random propositions, checked against an in-bench token predictor or typed rows.
// Depends on plex_pkg and the lexer RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 40000;
  localparam int unsigned RAND_ITEMS  = 145;
  localparam int unsigned DIR_ROWS    = 25;
  localparam int unsigned PB          = plex_pkg::POS_BITS;

  // Expected token plus its end-of-run flag.
  typedef struct packed {
    plex_pkg::token_t tok;
    logic             last;
  } tok_exp_t;

  // One directed row; the expectation is typed in only where typed is set,
  // and then the character causes exactly one token.
  typedef struct {
    logic [7:0]            ch;
    logic                  lst;
    logic                  typed;
    plex_pkg::token_kind_e kind;
    plex_pkg::error_kind_e err;
    logic [15:0]           pos;
  } dir_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  propositional_logic_lexer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Lexer shadow state
  plex_pkg::lex_mode_e lx_mode     = plex_pkg::MODE_IDLE;
  logic [PB-1:0]       lx_pos      = '0;
  logic [PB-1:0]       lx_id_start = '0;
  logic [PB-1:0]       lx_id_len   = '0;
  logic [PB-1:0]       lx_op_start = '0;
  plex_pkg::token_t    char_tokens[$];   // tokens caused by the current character

  tok_exp_t   pending_tokens[$];
  logic [7:0] prop_text[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt    = 0;
  int         burst_left   = 0;

  task automatic emit_token(input plex_pkg::token_kind_e k, input plex_pkg::error_kind_e e,
                            input logic [PB-1:0] p, input logic [PB-1:0] l);
    plex_pkg::token_t t;
    t.kind = k;
    t.err  = e;
    t.pos  = plex_pkg::to_out(p);
    t.len  = plex_pkg::to_out(l);
    char_tokens.insert(char_tokens.size(), t);
  endtask

  task automatic flush_ident();
    if (lx_mode == plex_pkg::MODE_NAME)
      emit_token(plex_pkg::TOK_VAR, plex_pkg::ERR_NONE, lx_id_start, lx_id_len);
    lx_mode = plex_pkg::MODE_IDLE;
  endtask

  // Advance the shadow lexer by one character; tokens land in char_tokens.
  task automatic lex_char(input logic [7:0] c, input logic lst);
    logic [PB-1:0]         p;
    logic                  bad;
    logic                  dig;
    logic                  namec;
    plex_pkg::token_kind_e k;
    char_tokens.delete();
    if (lx_mode == plex_pkg::MODE_DROP) begin
      if (lst) begin
        lx_mode = plex_pkg::MODE_IDLE;
        lx_pos  = '0;
      end
      return;
    end
    p     = lx_pos;
    bad   = 1'b0;
    dig   = (c >= plex_pkg::CH_DIG0) && (c <= plex_pkg::CH_DIG9);
    namec = dig || c == plex_pkg::CH_UNDER ||
            (c >= plex_pkg::CH_UPA && c <= plex_pkg::CH_UPZ) ||
            (c >= plex_pkg::CH_LOA && c <= plex_pkg::CH_LOZ);
    if (p == {PB{1'b1}}) begin
      emit_token(plex_pkg::TOK_ERROR, plex_pkg::ERR_TOO_LONG, p, '0);
      bad = 1'b1;
    end else if (lx_mode == plex_pkg::MODE_MINUS || lx_mode == plex_pkg::MODE_LTMINUS) begin
      if (c == plex_pkg::CH_GT) begin
        emit_token(lx_mode == plex_pkg::MODE_MINUS ? plex_pkg::TOK_IMPLIES : plex_pkg::TOK_IFF,
                   plex_pkg::ERR_NONE, lx_op_start, '0);
        lx_mode = plex_pkg::MODE_IDLE;
      end else begin
        emit_token(plex_pkg::TOK_ERROR, plex_pkg::ERR_BAD_ARROW, lx_op_start, '0);
        bad = 1'b1;
      end
    end else if (lx_mode == plex_pkg::MODE_LT) begin
      if (c == plex_pkg::CH_MINUS) begin
        lx_mode = plex_pkg::MODE_LTMINUS;
      end else begin
        emit_token(plex_pkg::TOK_ERROR, plex_pkg::ERR_BAD_ARROW, lx_op_start, '0);
        bad = 1'b1;
      end
    end else if (c == plex_pkg::CH_SPACE || c == plex_pkg::CH_TAB || c == plex_pkg::CH_NL) begin
      flush_ident();
    end else if (c == plex_pkg::CH_AMP || c == plex_pkg::CH_PIPE || c == plex_pkg::CH_BANG ||
                 c == plex_pkg::CH_LPAR || c == plex_pkg::CH_RPAR) begin
      case (c)
        plex_pkg::CH_AMP:  k = plex_pkg::TOK_AND;
        plex_pkg::CH_PIPE: k = plex_pkg::TOK_OR;
        plex_pkg::CH_BANG: k = plex_pkg::TOK_NOT;
        plex_pkg::CH_LPAR: k = plex_pkg::TOK_LPAREN;
        default:           k = plex_pkg::TOK_RPAREN;
      endcase
      flush_ident();
      emit_token(k, plex_pkg::ERR_NONE, p, '0);
    end else if (c == plex_pkg::CH_MINUS || c == plex_pkg::CH_LT) begin
      flush_ident();
      lx_op_start = p;
      lx_mode     = (c == plex_pkg::CH_MINUS) ? plex_pkg::MODE_MINUS : plex_pkg::MODE_LT;
    end else if (lx_mode == plex_pkg::MODE_IDLE && dig) begin
      emit_token(plex_pkg::TOK_ERROR, plex_pkg::ERR_DIGIT_FIRST, p, '0);
      bad = 1'b1;
    end else if (!namec) begin
      emit_token(plex_pkg::TOK_ERROR, plex_pkg::ERR_INVALID_CHAR, p, '0);
      bad = 1'b1;
    end else if (lx_mode == plex_pkg::MODE_IDLE) begin
      lx_id_start = p;
      lx_id_len   = PB'(1);
      lx_mode     = plex_pkg::MODE_NAME;
    end else begin
      lx_id_len = lx_id_len + PB'(1);
    end

    if (bad) lx_mode = plex_pkg::MODE_DROP;

    if (lst) begin
      if (!bad) begin
        if (lx_mode == plex_pkg::MODE_MINUS || lx_mode == plex_pkg::MODE_LT ||
            lx_mode == plex_pkg::MODE_LTMINUS) begin
          // arrow cut short by the end of the text
          emit_token(plex_pkg::TOK_ERROR, plex_pkg::ERR_BAD_ARROW, lx_op_start, '0);
        end else begin
          flush_ident();
          emit_token(plex_pkg::TOK_END, plex_pkg::ERR_NONE, p + PB'(1), '0);
        end
      end
      lx_mode = plex_pkg::MODE_IDLE;
      lx_pos  = '0;
    end else if (!bad) begin
      lx_pos = p + PB'(1);
    end
  endtask

  // Offer one character; the sender idles in bursts with random gaps.
  // On the accepting edge the expected tokens are queued.
  task automatic send_char(input logic [7:0] c, input logic lst, input logic typed,
                           input plex_pkg::token_t want);
    int gap;
    tok_exp_t e;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_tready);
    lex_char(c, lst);
    if (typed) begin
      e.tok  = want;
      e.last = 1'b1;
      pending_tokens.insert(pending_tokens.size(), e);
    end else begin
      foreach (char_tokens[i]) begin
        e.tok  = char_tokens[i];
        e.last = (i == char_tokens.size() - 1);
        pending_tokens.insert(pending_tokens.size(), e);
      end
    end
  endtask

  // Hold the sender off until every predicted token has come out.
  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Append one character to the proposition being built.
  task automatic add_char(input logic [7:0] c);
    prop_text.insert(prop_text.size(), c);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 2))
      0:       return plex_pkg::CH_SPACE;
      1:       return plex_pkg::CH_TAB;
      default: return plex_pkg::CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char(input bit first);
    case ($urandom_range(first ? 1 : 0, 3))
      0:       return 8'(plex_pkg::CH_DIG0 + $urandom_range(0, 9));
      1:       return 8'(plex_pkg::CH_UPA + $urandom_range(0, 25));
      2:       return 8'(plex_pkg::CH_LOA + $urandom_range(0, 25));
      default: return plex_pkg::CH_UNDER;
    endcase
  endfunction

  // Build one proposition into prop_text: mostly valid tokens with random
  // spacing, some errors, and now and then raw bytes.
  task automatic build_prop();
    int sel;
    prop_text.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 7)) begin
      sel = $urandom_range(0, 19);
      if (sel <= 6) begin
        add_char(pick_name_char(1'b1));
        repeat ($urandom_range(0, 3)) add_char(pick_name_char(1'b0));
      end else if (sel <= 10) begin
        case ($urandom_range(0, 4))
          0:       add_char(plex_pkg::CH_AMP);
          1:       add_char(plex_pkg::CH_PIPE);
          2:       add_char(plex_pkg::CH_BANG);
          3:       add_char(plex_pkg::CH_LPAR);
          default: add_char(plex_pkg::CH_RPAR);
        endcase
      end else if (sel <= 12) begin
        add_char(plex_pkg::CH_MINUS);
        add_char(plex_pkg::CH_GT);
      end else if (sel <= 14) begin
        add_char(plex_pkg::CH_LT);
        add_char(plex_pkg::CH_MINUS);
        add_char(plex_pkg::CH_GT);
      end else if (sel <= 16) begin
        add_char(pick_space());
      end else if (sel == 17) begin
        // name opening with a digit
        add_char(8'(plex_pkg::CH_DIG0 + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 2)) add_char(pick_name_char(1'b0));
      end else if (sel == 18) begin
        add_char(8'($urandom_range(0, 255)));
      end else begin
        // half an arrow
        add_char($urandom_range(0, 1) ? plex_pkg::CH_MINUS : plex_pkg::CH_LT);
        if ($urandom_range(0, 1)) add_char(plex_pkg::CH_MINUS);
      end
      if ($urandom_range(0, 1)) add_char(pick_space());
    end
  endtask

  // Receiver: phases of always ready, coin-flip ready, and mostly stalled.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Token checker
  always @(posedge clk_i) begin
    tok_exp_t got;
    tok_exp_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.tok.kind = plex_pkg::token_kind_e'(m_tuser);
      got.tok.err  = plex_pkg::error_kind_e'(m_tdata[2:0]);
      got.tok.pos  = m_tdata[18:3];
      got.tok.len  = m_tdata[34:19];
      got.last     = m_tlast;
      if (pending_tokens.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected token kind=%0d err=%0d pos=%0d len=%0d last=%0b",
                   $realtime, got.tok.kind, got.tok.err, got.tok.pos, got.tok.len, got.last);
      end else begin
        want = pending_tokens.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $write("%0t: token mismatch exp kind=%0d err=%0d pos=%0d len=%0d last=%0b",
                   $realtime, want.tok.kind, want.tok.err, want.tok.pos, want.tok.len,
                   want.last);
            $display(" got kind=%0d err=%0d pos=%0d len=%0d last=%0b",
                     got.tok.kind, got.tok.err, got.tok.pos, got.tok.len, got.last);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  dir_row_t dir_tab[DIR_ROWS] = '{
    '{plex_pkg::CH_LPAR,  1'b0, 1'b1, plex_pkg::TOK_LPAREN, plex_pkg::ERR_NONE, 16'd0},
    '{"a",                1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_UNDER, 1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_DIG9,  1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_AMP,   1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_BANG,  1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_PIPE,  1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_MINUS, 1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_GT,    1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_LT,    1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_MINUS, 1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_GT,    1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_TAB,   1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{"Z",                1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    // var, ')', end
    '{plex_pkg::CH_RPAR,  1'b1, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_DIG0,  1'b0, 1'b1, plex_pkg::TOK_ERROR,
      plex_pkg::ERR_DIGIT_FIRST, 16'd0},
    '{"q",                1'b1, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},  // dropped
    '{plex_pkg::CH_MINUS, 1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{"x",                1'b0, 1'b1, plex_pkg::TOK_ERROR,
      plex_pkg::ERR_BAD_ARROW, 16'd0},
    '{8'hFF,              1'b1, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},  // dropped
    // text ends mid-arrow
    '{plex_pkg::CH_LT,    1'b1, 1'b1, plex_pkg::TOK_ERROR,
      plex_pkg::ERR_BAD_ARROW, 16'd0},
    '{plex_pkg::CH_SPACE, 1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{plex_pkg::CH_NL,    1'b0, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0},
    '{8'h00,              1'b0, 1'b1, plex_pkg::TOK_ERROR,
      plex_pkg::ERR_INVALID_CHAR, 16'd2},
    '{8'h80,              1'b1, 1'b0, plex_pkg::TOK_VAR,    plex_pkg::ERR_NONE, 16'd0}   // dropped
  };

  initial begin
    plex_pkg::token_t want;
    int               rand_items;
    bit               paused;
    rand_items = 0;
    paused     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[i]) begin
      want.kind = dir_tab[i].kind;
      want.err  = dir_tab[i].err;
      want.pos  = dir_tab[i].pos;
      want.len  = '0;
      send_char(dir_tab[i].ch, dir_tab[i].lst, dir_tab[i].typed, want);
    end
    drain_tokens();

    // random propositions
    while (rand_items < RAND_ITEMS) begin
      build_prop();
      foreach (prop_text[i])
        send_char(prop_text[i], i == prop_text.size() - 1, 1'b0, '0);
      rand_items += prop_text.size();
      if (!paused && rand_items >= RAND_ITEMS / 2) begin
        drain_tokens();
        paused = 1'b1;
      end
    end
    s_tvalid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== propositional_logic_lexer.f =====
sv/plex_pkg.sv
sv/plex_front.sv
sv/plex_queue.sv
sv/plex_back.sv
sv/propositional_logic_lexer.sv
verif/tb_top.sv
